// ===== hdl/hule_pkg.sv =====
// Shared types, character codes and helper functions of the hex upload line editor.
// No dependencies; used by hule_ctrl, hule_datapath and the top level.
package hule_pkg;

    localparam logic       OP_BEGIN   = 1'b0;
    localparam logic       OP_CHAR    = 1'b1;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [7:0] CHAR_BELL  = 8'h07;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PROMPT,
        ST_BKSP,
        ST_BELL,
        ST_ECHO,
        ST_CRLF,
        ST_DONE,
        ST_SCAN_ADDR,
        ST_SCAN_DATA
    } state_t;

    typedef enum logic [3:0] {
        EMIT_DIGIT3,
        EMIT_DIGIT2,
        EMIT_DIGIT1,
        EMIT_DIGIT0,
        EMIT_SPACE,
        EMIT_COLON,
        EMIT_BS,
        EMIT_BELL,
        EMIT_ECHO,
        EMIT_CR,
        EMIT_LF,
        EMIT_WRITE,
        EMIT_DONE
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      start;
        logic      store;
        logic      drop;
        logic      clear_line;
        logic      scan_init;
        logic      rd_en;
        logic      take_nibble;
        logic      skip;
        logic      emit;
        emit_sel_t sel;
        logic      last;
        logic      close;
    } hule_cmd_t;

    typedef struct packed {
        logic op;
        logic session;
        logic is_bksp;
        logic is_enter;
        logic is_ctrl;
        logic line_empty;
        logic line_full;
        logic scan_end;
        logic rd_hex;
        logic high;
        logic out_free;
    } hule_status_t;

    // {valid, value} of an ASCII hex digit of either case
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic logic [7:0] hex_glyph(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + {4'h0, n};
        end
        return 8'h37 + {4'h0, n};
    endfunction

endpackage

// ===== hdl/hule_ctrl.sv =====
// Sequencing state machine of the hex upload line editor.
// Depends on hule_pkg; drives hule_datapath through command and status structs.
module hule_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  hule_pkg::hule_status_t status,
    output hule_pkg::hule_cmd_t    cmd
);

    hule_pkg::state_t state_reg, state_next;
    logic [2:0]       step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hule_pkg::ST_IDLE;
            step_reg  <= 3'd0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            hule_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = hule_pkg::ST_DECODE;
                end
            end
            hule_pkg::ST_DECODE: begin
                step_next = 3'd0;
                if (status.op == hule_pkg::OP_BEGIN) begin
                    state_next = hule_pkg::ST_PROMPT;
                end else if (!status.session) begin
                    state_next = hule_pkg::ST_IDLE;
                end else if (status.is_bksp) begin
                    state_next = status.line_empty ? hule_pkg::ST_BELL : hule_pkg::ST_BKSP;
                end else if (status.is_enter) begin
                    state_next = hule_pkg::ST_CRLF;
                end else if (status.is_ctrl || status.line_full) begin
                    state_next = hule_pkg::ST_BELL;
                end else begin
                    state_next = hule_pkg::ST_ECHO;
                end
            end
            hule_pkg::ST_PROMPT: begin
                if (status.out_free) begin
                    step_next = step_reg + 3'd1;
                    if (step_reg == 3'd6) begin
                        state_next = hule_pkg::ST_IDLE;
                    end
                end
            end
            hule_pkg::ST_BKSP: begin
                if (status.out_free) begin
                    step_next = step_reg + 3'd1;
                    if (step_reg == 3'd2) begin
                        state_next = hule_pkg::ST_IDLE;
                    end
                end
            end
            hule_pkg::ST_BELL, hule_pkg::ST_ECHO, hule_pkg::ST_DONE: begin
                if (status.out_free) begin
                    state_next = hule_pkg::ST_IDLE;
                end
            end
            hule_pkg::ST_CRLF: begin
                if (status.out_free) begin
                    step_next = step_reg + 3'd1;
                    if (step_reg == 3'd1) begin
                        state_next = status.line_empty ? hule_pkg::ST_DONE
                                                       : hule_pkg::ST_SCAN_ADDR;
                    end
                end
            end
            hule_pkg::ST_SCAN_ADDR: begin
                step_next = 3'd0;
                state_next = status.scan_end ? hule_pkg::ST_PROMPT : hule_pkg::ST_SCAN_DATA;
            end
            hule_pkg::ST_SCAN_DATA: begin
                if (!status.rd_hex || status.high || status.out_free) begin
                    state_next = hule_pkg::ST_SCAN_ADDR;
                end
            end
            default: begin
                state_next = hule_pkg::ST_IDLE;
                step_next  = 3'd0;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        cmd.sel  = hule_pkg::EMIT_BELL;
        s_tready = 1'b0;
        case (state_reg)
            hule_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            hule_pkg::ST_DECODE: begin
                if (status.op == hule_pkg::OP_BEGIN) begin
                    cmd.start = 1'b1;
                end else if (status.session && !status.is_bksp && !status.is_enter
                             && !status.is_ctrl && !status.line_full) begin
                    cmd.store = 1'b1;
                end
            end
            hule_pkg::ST_PROMPT: begin
                cmd.emit = status.out_free;
                cmd.last = (step_reg == 3'd6);
                case (step_reg)
                    3'd0:    cmd.sel = hule_pkg::EMIT_DIGIT3;
                    3'd1:    cmd.sel = hule_pkg::EMIT_DIGIT2;
                    3'd2:    cmd.sel = hule_pkg::EMIT_DIGIT1;
                    3'd3:    cmd.sel = hule_pkg::EMIT_DIGIT0;
                    3'd5:    cmd.sel = hule_pkg::EMIT_COLON;
                    default: cmd.sel = hule_pkg::EMIT_SPACE;
                endcase
            end
            hule_pkg::ST_BKSP: begin
                cmd.emit = status.out_free;
                cmd.last = (step_reg == 3'd2);
                cmd.drop = status.out_free && (step_reg == 3'd2);
                cmd.sel  = (step_reg == 3'd1) ? hule_pkg::EMIT_SPACE : hule_pkg::EMIT_BS;
            end
            hule_pkg::ST_BELL: begin
                cmd.emit = status.out_free;
                cmd.last = 1'b1;
                cmd.sel  = hule_pkg::EMIT_BELL;
            end
            hule_pkg::ST_ECHO: begin
                cmd.emit = status.out_free;
                cmd.last = 1'b1;
                cmd.sel  = hule_pkg::EMIT_ECHO;
            end
            hule_pkg::ST_DONE: begin
                cmd.emit  = status.out_free;
                cmd.last  = 1'b1;
                cmd.close = status.out_free;
                cmd.sel   = hule_pkg::EMIT_DONE;
            end
            hule_pkg::ST_CRLF: begin
                cmd.emit      = status.out_free;
                cmd.sel       = (step_reg == 3'd0) ? hule_pkg::EMIT_CR : hule_pkg::EMIT_LF;
                cmd.scan_init = status.out_free && (step_reg == 3'd1);
            end
            hule_pkg::ST_SCAN_ADDR: begin
                cmd.clear_line = status.scan_end;
                cmd.rd_en      = !status.scan_end;
            end
            hule_pkg::ST_SCAN_DATA: begin
                cmd.sel         = hule_pkg::EMIT_WRITE;
                cmd.skip        = !status.rd_hex;
                cmd.take_nibble = status.rd_hex && status.high;
                cmd.emit        = status.rd_hex && !status.high && status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/hule_datapath.sv =====
// Datapath of the hex upload line editor: input latch, line store, scan and output register.
// Depends on hule_pkg; commanded by hule_ctrl.
module hule_datapath #(
    parameter int LINE_LENGTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tuser,
    input  logic [23:0]           s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast,
    input  hule_pkg::hule_cmd_t    cmd,
    output hule_pkg::hule_status_t status
);

    localparam int AW = (LINE_LENGTH > 1) ? $clog2(LINE_LENGTH) : 1;
    localparam int CW = $clog2(LINE_LENGTH + 1);
    localparam logic [CW-1:0] LINE_MAX = CW'(LINE_LENGTH);

    logic             op_reg;
    logic [15:0]      start_addr_reg;
    logic [7:0]       rx_char_reg;
    logic [7:0]       rd_data_reg;
    logic [7:0]       line_mem [LINE_LENGTH];

    logic             session_reg, session_next;
    logic [CW-1:0]    line_count_reg, line_count_next;
    logic [15:0]      write_addr_reg, write_addr_next;
    logic [CW-1:0]    scan_idx_reg, scan_idx_next;
    logic             high_reg, high_next;
    logic [3:0]       acc_reg, acc_next;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_kind_reg;
    logic [7:0]       out_tx_reg;
    logic [15:0]      out_addr_reg;
    logic [7:0]       out_data_reg;
    logic             out_last_reg;

    logic [4:0]       rd_hex;
    logic             out_free;
    logic             advance;
    logic [1:0]       emit_kind;
    logic [7:0]       emit_tx;
    logic [15:0]      emit_addr;
    logic [7:0]       emit_data;

    assign rd_hex   = hule_pkg::hex_decode(rd_data_reg);
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = cmd.skip || cmd.take_nibble
                      || (cmd.emit && cmd.sel == hule_pkg::EMIT_WRITE);

    assign status.op         = op_reg;
    assign status.session    = session_reg;
    assign status.is_bksp    = (rx_char_reg == hule_pkg::CHAR_BS)
                               || (rx_char_reg == hule_pkg::CHAR_DEL);
    assign status.is_enter   = (rx_char_reg == hule_pkg::CHAR_LF)
                               || (rx_char_reg == hule_pkg::CHAR_CR);
    assign status.is_ctrl    = (rx_char_reg < hule_pkg::CHAR_SPACE);
    assign status.line_empty = (line_count_reg == '0);
    assign status.line_full  = (line_count_reg >= LINE_MAX);
    assign status.scan_end   = (scan_idx_reg == line_count_reg);
    assign status.rd_hex     = rd_hex[4];
    assign status.high       = high_reg;
    assign status.out_free   = out_free;

    // input latch and line store
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg         <= s_tuser;
            start_addr_reg <= s_tdata[15:0];
            rx_char_reg    <= s_tdata[23:16];
        end
        if (cmd.store) begin
            line_mem[line_count_reg[AW-1:0]] <= rx_char_reg;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= line_mem[scan_idx_reg[AW-1:0]];
        end
    end

    always_comb begin
        session_next    = session_reg;
        line_count_next = line_count_reg;
        write_addr_next = write_addr_reg;
        scan_idx_next   = scan_idx_reg;
        high_next       = high_reg;
        acc_next        = acc_reg;
        if (cmd.start) begin
            session_next    = 1'b1;
            line_count_next = '0;
            write_addr_next = start_addr_reg;
        end
        if (cmd.close) begin
            session_next = 1'b0;
        end
        if (cmd.store) begin
            line_count_next = line_count_reg + CW'(1);
        end
        if (cmd.drop) begin
            line_count_next = line_count_reg - CW'(1);
        end
        if (cmd.clear_line) begin
            line_count_next = '0;
        end
        if (cmd.scan_init) begin
            scan_idx_next = '0;
            high_next     = 1'b1;
        end
        if (cmd.take_nibble) begin
            acc_next  = rd_hex[3:0];
            high_next = 1'b0;
        end
        if (cmd.emit && cmd.sel == hule_pkg::EMIT_WRITE) begin
            write_addr_next = write_addr_reg + 16'd1;
            high_next       = 1'b1;
        end
        if (advance) begin
            scan_idx_next = scan_idx_reg + CW'(1);
        end
    end

    // result field selection
    always_comb begin
        emit_kind = hule_pkg::KIND_CHAR;
        emit_tx   = 8'h00;
        emit_addr = 16'h0000;
        emit_data = 8'h00;
        case (cmd.sel)
            hule_pkg::EMIT_DIGIT3: emit_tx = hule_pkg::hex_glyph(write_addr_reg[15:12]);
            hule_pkg::EMIT_DIGIT2: emit_tx = hule_pkg::hex_glyph(write_addr_reg[11:8]);
            hule_pkg::EMIT_DIGIT1: emit_tx = hule_pkg::hex_glyph(write_addr_reg[7:4]);
            hule_pkg::EMIT_DIGIT0: emit_tx = hule_pkg::hex_glyph(write_addr_reg[3:0]);
            hule_pkg::EMIT_SPACE:  emit_tx = hule_pkg::CHAR_SPACE;
            hule_pkg::EMIT_COLON:  emit_tx = hule_pkg::CHAR_COLON;
            hule_pkg::EMIT_BS:     emit_tx = hule_pkg::CHAR_BS;
            hule_pkg::EMIT_BELL:   emit_tx = hule_pkg::CHAR_BELL;
            hule_pkg::EMIT_ECHO:   emit_tx = rx_char_reg;
            hule_pkg::EMIT_CR:     emit_tx = hule_pkg::CHAR_CR;
            hule_pkg::EMIT_LF:     emit_tx = hule_pkg::CHAR_LF;
            hule_pkg::EMIT_WRITE: begin
                emit_kind = hule_pkg::KIND_WRITE;
                emit_addr = write_addr_reg;
                emit_data = {acc_reg, rd_hex[3:0]};
            end
            hule_pkg::EMIT_DONE:   emit_kind = hule_pkg::KIND_DONE;
            default:               emit_tx = 8'h00;
        endcase
    end

    // hold the result until the far side takes it
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            session_reg    <= 1'b0;
            line_count_reg <= '0;
            write_addr_reg <= 16'h0000;
            scan_idx_reg   <= '0;
            high_reg       <= 1'b1;
            acc_reg        <= 4'h0;
            out_valid_reg  <= 1'b0;
        end else begin
            session_reg    <= session_next;
            line_count_reg <= line_count_next;
            write_addr_reg <= write_addr_next;
            scan_idx_reg   <= scan_idx_next;
            high_reg       <= high_next;
            acc_reg        <= acc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_kind_reg <= emit_kind;
            out_tx_reg   <= emit_tx;
            out_addr_reg <= emit_addr;
            out_data_reg <= emit_data;
            out_last_reg <= cmd.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg, out_addr_reg, out_tx_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== hdl/hex_upload_line_editor_core.sv =====
// Top level of the hex upload line editor: controller plus datapath.
// Depends on hule_pkg, hule_ctrl and hule_datapath.
//
// Serial hex upload loader with line editing. A begin request (s_tuser = 0) opens a session at
// start_address and sends the prompt "AAAA : "; character requests (s_tuser = 1) are edited
// into a line store and echoed, and Enter turns the line's hex digit pairs into memory write
// results followed by a fresh prompt, or closes the session on an empty line. One request is
// handled at a time: it is decoded, then its results are sent in order. On an Enter on a
// non-empty line the line store is walked one entry at a time through its single registered
// read port: each entry is read, then skipped if it is not a hex digit, kept as the high
// nibble, or sent with the kept nibble as a write. A stalled result register holds the sequence
// until it frees. The next request is taken while the final result still waits.
module hex_upload_line_editor_core #(
    parameter int LINE_LENGTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // start_address [15:0], rx_char [23:16]
    input  logic        s_tuser,  // operation [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // tx_char [7:0], mem_address [23:8], mem_data [31:24]
    output logic [1:0]  m_tuser,  // kind [1:0]
    output logic        m_tlast
);

    hule_pkg::hule_cmd_t    cmd;
    hule_pkg::hule_status_t status;

    hule_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hule_datapath #(
        .LINE_LENGTH (LINE_LENGTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

// ===== test/tb.sv =====
// Self-checking bench for hex_upload_line_editor_core: prompts, line editing, hex writes.
// Depends on hule_pkg and the core; keeps its own line editor state to predict every result.
module tb;

    localparam int LINE_LEN       = 64;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    // first glyph sits in the top byte
    localparam logic [127:0] HEX_GLYPHS = "0123456789ABCDEF";

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        last;
    } reply_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        s_tuser  = hule_pkg::OP_BEGIN;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // mirror of the editor state
    logic        session_on = 1'b0;
    logic [7:0]  line_buf [LINE_LEN];
    int          line_len   = 0;
    logic [15:0] wr_addr    = '0;
    int          step_replies;

    reply_t reply_q [$];

    bit gaps_on   = 1'b1;
    int hold_req  = 0;
    int hold_left = 0;
    int errors    = 0;
    int n_items   = 0;
    int n_results = 0;
    int n_writes  = 0;
    int n_closed  = 0;
    int stall_cycles = 0;

    hex_upload_line_editor_core #(
        .LINE_LENGTH(LINE_LEN)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] glyph_of(input logic [3:0] n);
        return HEX_GLYPHS[8 * (15 - n) +: 8];
    endfunction

    function automatic int digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    function automatic void push_reply(input logic [1:0] kind, input logic [7:0] tx,
                                       input logic [15:0] addr, input logic [7:0] data);
        reply_t r;
        r = '{kind: kind, tx: tx, addr: addr, data: data, last: 1'b0};
        reply_q.push_back(r);
        step_replies++;
    endfunction

    function automatic void push_prompt();
        push_reply(hule_pkg::KIND_CHAR, glyph_of(wr_addr[15:12]), '0, '0);
        push_reply(hule_pkg::KIND_CHAR, glyph_of(wr_addr[11:8]), '0, '0);
        push_reply(hule_pkg::KIND_CHAR, glyph_of(wr_addr[7:4]), '0, '0);
        push_reply(hule_pkg::KIND_CHAR, glyph_of(wr_addr[3:0]), '0, '0);
        push_reply(hule_pkg::KIND_CHAR, hule_pkg::CHAR_SPACE, '0, '0);
        push_reply(hule_pkg::KIND_CHAR, hule_pkg::CHAR_COLON, '0, '0);
        push_reply(hule_pkg::KIND_CHAR, hule_pkg::CHAR_SPACE, '0, '0);
    endfunction

    // work out every result one accepted request causes
    function automatic void predict_request(input logic op, input logic [15:0] addr,
                                            input logic [7:0] ch);
        bit         upper_pending;
        logic [7:0] acc;
        int         v;
        step_replies = 0;
        if (op == hule_pkg::OP_BEGIN) begin
            wr_addr    = addr;
            line_len   = 0;
            session_on = 1'b1;
            push_prompt();
        end else if (!session_on) begin
            // ignored while no session is open
        end else if (ch == hule_pkg::CHAR_BS || ch == hule_pkg::CHAR_DEL) begin
            if (line_len > 0) begin
                push_reply(hule_pkg::KIND_CHAR, hule_pkg::CHAR_BS, '0, '0);
                push_reply(hule_pkg::KIND_CHAR, hule_pkg::CHAR_SPACE, '0, '0);
                push_reply(hule_pkg::KIND_CHAR, hule_pkg::CHAR_BS, '0, '0);
                line_len--;
            end else begin
                push_reply(hule_pkg::KIND_CHAR, hule_pkg::CHAR_BELL, '0, '0);
            end
        end else if (ch == hule_pkg::CHAR_LF || ch == hule_pkg::CHAR_CR) begin
            push_reply(hule_pkg::KIND_CHAR, hule_pkg::CHAR_CR, '0, '0);
            push_reply(hule_pkg::KIND_CHAR, hule_pkg::CHAR_LF, '0, '0);
            if (line_len == 0) begin
                session_on = 1'b0;
                push_reply(hule_pkg::KIND_DONE, '0, '0, '0);
            end else begin
                upper_pending = 1'b1;
                acc = '0;
                for (int i = 0; i < line_len; i++) begin
                    v = digit_value(line_buf[i]);
                    if (v < 0) continue;
                    if (upper_pending) begin
                        acc = {v[3:0], 4'h0};
                    end else begin
                        acc[3:0] = v[3:0];
                        push_reply(hule_pkg::KIND_WRITE, '0, wr_addr, acc);
                        wr_addr = wr_addr + 16'd1;
                    end
                    upper_pending = !upper_pending;
                end
                line_len = 0;
                push_prompt();
            end
        end else if (ch < hule_pkg::CHAR_SPACE || line_len >= LINE_LEN) begin
            push_reply(hule_pkg::KIND_CHAR, hule_pkg::CHAR_BELL, '0, '0);
        end else begin
            line_buf[line_len] = ch;
            line_len++;
            push_reply(hule_pkg::KIND_CHAR, ch, '0, '0);
        end
        if (step_replies > 0) reply_q[reply_q.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got 0x%0h, want 0x%0h", n_results, what, got, want);
        errors++;
    endtask

    // offer one request from the falling edge and hold it until taken
    task automatic send_request(input logic op, input logic [15:0] addr, input logic [7:0] ch);
        @(negedge aclk);
        while (gaps_on && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {ch, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_request(op, addr, ch);
        n_items++;
    endtask

    task automatic send_begin(input logic [15:0] addr);
        send_request(hule_pkg::OP_BEGIN, addr, 8'($urandom));
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_request(hule_pkg::OP_CHAR, 16'($urandom), ch);
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (reply_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] random_hex_char();
        logic [3:0] v;
        logic [7:0] c;
        v = 4'($urandom_range(0, 15));
        c = glyph_of(v);
        if (v >= 4'd10 && $urandom_range(0, 1) == 1) c = c + 8'h20;
        return c;
    endfunction

    function automatic logic [7:0] random_line_char();
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            c = random_hex_char();
        end else if (r < 75) begin
            c = 8'($urandom_range(32, 255));
            if (c == hule_pkg::CHAR_DEL) c = 8'h7E;
        end else if (r < 87) begin
            c = ($urandom_range(0, 1) == 1) ? hule_pkg::CHAR_BS : hule_pkg::CHAR_DEL;
        end else begin
            c = 8'($urandom_range(0, 31));
            if (c == hule_pkg::CHAR_BS || c == hule_pkg::CHAR_LF || c == hule_pkg::CHAR_CR)
                c = hule_pkg::CHAR_BELL;
        end
        return c;
    endfunction

    function automatic logic [7:0] random_enter();
        return ($urandom_range(0, 1) == 1) ? hule_pkg::CHAR_CR : hule_pkg::CHAR_LF;
    endfunction

    task automatic test_idle_and_prompts();
        send_char("A");
        send_char(hule_pkg::CHAR_CR);
        send_char(hule_pkg::CHAR_BS);
        send_begin(16'h0000);
        send_begin(16'hFFFF);
        send_char("x");
        // restart mid-line
        send_begin(16'hA5C3);
        wait_for_results();
    endtask

    task automatic test_line_editing();
        send_begin(16'hFFFE);
        send_char(hule_pkg::CHAR_BS);
        send_char(8'h00);
        send_char(8'h1F);
        send_char(8'h80);
        send_char(8'hFF);
        send_char(hule_pkg::CHAR_DEL);
        send_char(hule_pkg::CHAR_BS);
        // pairs skip non-hex, odd nibble dropped, address wraps
        send_char("c");
        send_char("0");
        send_char("d");
        send_char("E");
        send_char("Z");
        send_char(":");
        send_char("9");
        send_char("9");
        send_char("7");
        send_char(hule_pkg::CHAR_CR);
        send_char(hule_pkg::CHAR_LF);
        wait_for_results();
    endtask

    task automatic test_line_overflow();
        send_begin(16'($urandom));
        repeat (LINE_LEN) send_char(random_hex_char());
        send_char("A");
        send_char(8'h90);
        send_char(hule_pkg::CHAR_DEL);
        send_char("E");
        send_char(random_enter());
        send_char(random_enter());
        wait_for_results();
    endtask

    task automatic test_streaming();
        gaps_on = 1'b0;
        send_begin(16'($urandom));
        repeat (3) begin
            repeat (10) send_char(random_line_char());
            send_char(random_enter());
        end
        send_char(random_enter());
        wait_for_results();
        gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        hold_req = HOLD_CYCLES;
        send_begin(16'($urandom));
        repeat (16) send_char(random_hex_char());
        send_char(random_enter());
        send_char(random_enter());
        wait_for_results();
    endtask

    task automatic test_random_sessions();
        int budget;
        int len;
        budget = 60;
        while (budget > 0) begin
            if ($urandom_range(0, 3) == 0) begin
                send_char(8'($urandom));
                budget--;
            end
            if ($urandom_range(0, 4) == 0) send_begin(16'($urandom_range(16'hFFF8, 16'hFFFF)));
            else send_begin(16'($urandom));
            budget--;
            repeat ($urandom_range(1, 4)) begin
                len = $urandom_range(1, 12);
                repeat (len) send_char(random_line_char());
                send_char(random_enter());
                budget -= len + 1;
            end
            // mostly close with an empty line, else leave it for the next begin
            if ($urandom_range(0, 99) < 85) begin
                send_char(random_enter());
                budget--;
            end
            if ($urandom_range(0, 4) == 0) wait_for_results();
        end
        wait_for_results();
    endtask

    always @(negedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(gaps_on && $urandom_range(0, 99) < 30);
        end
    end

    always @(posedge aclk) begin : check_results
        reply_t got;
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{kind: m_tuser, tx: m_tdata[7:0], addr: m_tdata[23:8],
                    data: m_tdata[31:24], last: m_tlast};
            n_results++;
            if (got.kind == hule_pkg::KIND_WRITE) n_writes++;
            if (got.kind == hule_pkg::KIND_DONE) n_closed++;
            if (reply_q.size() == 0) begin
                report_mismatch("result with nothing pending, kind", got.kind, 0);
            end else begin
                want = reply_q.pop_front();
                if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
                if (got.tx != want.tx) report_mismatch("tx_char", got.tx, want.tx);
                if (got.addr != want.addr) report_mismatch("mem_address", got.addr, want.addr);
                if (got.data != want.data) report_mismatch("mem_data", got.data, want.data);
                if (got.last != want.last) report_mismatch("last", got.last, want.last);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", stall_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_and_prompts();
        test_line_editing();
        test_line_overflow();
        test_streaming();
        test_backpressure();
        test_random_sessions();

        // let any late result surface
        repeat (200) @(posedge aclk);
        if (reply_q.size() != 0) begin
            $display("%0d expected results never arrived", reply_q.size());
            errors += reply_q.size();
        end
        $display("sent %0d requests, checked %0d results: %0d memory writes, %0d sessions closed",
                 n_items, n_results, n_writes, n_closed);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
